// File: rtl/mbp_pkg.sv
package mbp_pkg;

  localparam int NumInputs  = 2;
  localparam int NumHidden  = 2;
  localparam int NumIh      = NumInputs * NumHidden;
  localparam int NumBias    = NumHidden + 1;

  localparam logic [31:0] QOne     = 32'd65536;
  localparam logic [16:0] LrReset  = 17'd13107;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_TRAIN = 1'b1;

  // Load index map
  localparam logic [3:0] IdxWho  = 4'd4;
  localparam logic [3:0] IdxBias = 4'd6;
  localparam logic [3:0] IdxEnd  = 4'd9;

  typedef logic signed [31:0] q_t;

  // Sigmoid samples at x = 0, 0.5, ..., 8
  localparam logic [15:0] SigTable [17] = '{
    16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
    16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
    16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
  };

  // Saturate a wide signed value to 32 bits
  function automatic q_t sat32(input logic signed [47:0] v);
    q_t r;
    if (v > 48'sh0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -48'sh0000_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: rtl/mbp_mul.sv
module mbp_mul import mbp_pkg::*; (
  input  logic clk_i,
  input  q_t   a_i,
  input  q_t   b_i,
  output q_t   p_o
);

  logic signed [63:0] prod;
  logic signed [47:0] shifted;

  // Q16.16 product, round half up, saturate
  always_comb begin
    prod    = a_i * b_i;
    shifted = 48'((prod + 64'sd32768) >>> 16);
  end

  always_ff @(posedge clk_i) begin
    p_o <= sat32(shifted);
  end

endmodule

// File: rtl/mbp_sigmoid.sv
module mbp_sigmoid import mbp_pkg::*; (
  input  q_t          x_i,
  output logic [16:0] y_o
);

  logic [32:0] ax;
  logic [3:0]  k;
  logic [14:0] frac;
  logic [15:0] d;
  logic [30:0] dprod;
  logic [16:0] y;

  // Table lookup with linear interpolation, mirrored for negative input
  always_comb begin
    ax    = x_i[31] ? 33'(-$signed({x_i[31], x_i})) : {1'b0, x_i};
    k     = ax[18:15];
    frac  = ax[14:0];
    d     = SigTable[5'(k) + 5'd1] - SigTable[k];
    dprod = 31'(d) * 31'(frac);
    if (ax >= 33'h8_0000) y = 17'(SigTable[16]);
    else y = 17'(SigTable[k]) + 17'(dprod >> 15);
    y_o = x_i[31] ? (17'd65536 - y) : y;
  end

endmodule

// File: rtl/mlp_backprop_train_step_core.sv
// 2-2-1 sigmoid network training engine with signed Q16.16 arithmetic.
// Input stream (s_axis): tuser = operation (0 load, 1 train); tdata holds
// param_index, param_value, input_a, input_b, target.
// A load writes one weight or bias; its zero result passes through ST_DONE
// to the output register.
// A train item runs the forward pass, then one backpropagation update, on a
// single shared 32x32 multiplier; its dependent multiplies run through that
// unit one sequencer state after another, and the result is then handed to
// the output register. One item is in work at a time: s_axis_tready is high
// only while the sequencer is idle, so a new item is accepted only after the
// last one has left ST_DONE.
// Output stream (m_axis): tdata holds net_output and squared_error. The
// result sits in an output register; a stalled receiver holds it, and the
// next item may be accepted meanwhile but waits at its end for the register.
// Config channel: cfg_valid_i/cfg_ready_o write the 17-bit learning rate
// (unsigned Q1.16); write only while idle.
// Reset clears all weights and biases to zero and sets the rate to 0.2.
module mlp_backprop_train_step_core import mbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [3:0] param_index, [35:4] param_value, [36] input_a, [37] input_b, [38] target
  input  logic [39:0] s_axis_tdata_i,
  // [0] operation
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [16:0] net_output, [33:17] squared_error
  output logic [39:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_HID0, ST_HID1, ST_OUT0, ST_OUT1, ST_OUT2, ST_OSIG,
    ST_OD0, ST_OD1, ST_OD2, ST_SQ,
    ST_U0, ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_U6, ST_U7, ST_U8,
    ST_BO0, ST_BO1, ST_DONE
  } state_e;

  state_e      state_q;
  logic [16:0] lr_q;
  q_t          wih_q [NumIh];
  q_t          who_q [NumHidden];
  q_t          bias_q [NumBias];
  logic        xa_q, xb_q, tgt_q, h_q;
  q_t          sigin_q, acc_q, og_q, hg_q;
  logic [16:0] hid_q [NumHidden];
  logic [16:0] o_q, sq_q;
  logic        mval_q;
  logic [33:0] mdata_q;

  q_t          mul_a, mul_b, mr, err, lr_s, hid_s;
  logic [16:0] sig_y;
  logic        s_acc, out_free;

  mbp_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(mr));
  mbp_sigmoid u_sig (.x_i(sigin_q), .y_o(sig_y));

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = mval_q;
  assign m_axis_tdata_o  = {6'd0, mdata_q};
  assign out_free        = !mval_q || m_axis_tready_i;

  assign lr_s  = q_t'({15'd0, lr_q});
  assign hid_s = q_t'({15'd0, hid_q[h_q]});
  assign err   = tgt_q ? (QOne - q_t'({15'd0, o_q})) : -q_t'({15'd0, o_q});

  // Hidden node input: weights gated by input bits, minus bias
  function automatic q_t hsum(input q_t w0, input q_t w1, input logic a,
                              input logic b, input q_t bi);
    logic signed [47:0] s;
    s = (a ? 48'(w0) : 48'sd0) + (b ? 48'(w1) : 48'sd0) - 48'(bi);
    return sat32(s);
  endfunction

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_OUT0: begin mul_a = who_q[0]; mul_b = q_t'({15'd0, hid_q[0]}); end
      ST_OUT1: begin mul_a = who_q[1]; mul_b = q_t'({15'd0, hid_q[1]}); end
      ST_OD0:  begin mul_a = q_t'({15'd0, o_q}); mul_b = QOne - q_t'({15'd0, o_q}); end
      ST_OD1:  begin mul_a = mr; mul_b = err; end
      ST_OD2:  begin mul_a = err; mul_b = err; end
      ST_U0:   begin mul_a = lr_s; mul_b = hid_s; end
      ST_U1:   begin mul_a = mr; mul_b = og_q; end
      ST_U2:   begin mul_a = hid_s; mul_b = QOne - hid_s; end
      ST_U3:   begin mul_a = mr; mul_b = og_q; end
      ST_U4:   begin mul_a = mr; mul_b = who_q[h_q]; end
      ST_U5:   begin mul_a = xa_q ? lr_s : '0; mul_b = mr; end
      ST_U6:   begin mul_a = xb_q ? lr_s : '0; mul_b = hg_q; end
      ST_U7:   begin mul_a = lr_s; mul_b = hg_q; end
      ST_BO0:  begin mul_a = lr_s; mul_b = og_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Sequencer, parameter file and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lr_q    <= LrReset;
      mval_q  <= 1'b0;
      h_q     <= 1'b0;
      for (int i = 0; i < NumIh; i++) wih_q[i] <= '0;
      for (int i = 0; i < NumHidden; i++) who_q[i] <= '0;
      for (int i = 0; i < NumBias; i++) bias_q[i] <= '0;
    end else begin
      if (cfg_valid_i) lr_q <= cfg_data_i;
      // in ST_DONE the output register is reloaded below instead
      if (mval_q && m_axis_tready_i && state_q != ST_DONE) mval_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            xa_q  <= s_axis_tdata_i[36];
            xb_q  <= s_axis_tdata_i[37];
            tgt_q <= s_axis_tdata_i[38];
            if (s_axis_tuser_i == OP_TRAIN) begin
              state_q <= ST_HID0;
            end else begin
              o_q     <= '0;
              sq_q    <= '0;
              state_q <= ST_DONE;
              if (s_axis_tdata_i[3:0] < IdxWho)
                wih_q[s_axis_tdata_i[1:0]] <= s_axis_tdata_i[35:4];
              else if (s_axis_tdata_i[3:0] < IdxBias)
                who_q[s_axis_tdata_i[0]] <= s_axis_tdata_i[35:4];
              else if (s_axis_tdata_i[3:0] < IdxEnd)
                bias_q[2'(s_axis_tdata_i[3:0] - IdxBias)] <= s_axis_tdata_i[35:4];
            end
          end
        end
        ST_HID0: begin
          sigin_q <= hsum(wih_q[0], wih_q[2], xa_q, xb_q, bias_q[0]);
          state_q <= ST_HID1;
        end
        ST_HID1: begin
          hid_q[0] <= sig_y;
          sigin_q  <= hsum(wih_q[1], wih_q[3], xa_q, xb_q, bias_q[1]);
          state_q  <= ST_OUT0;
        end
        ST_OUT0: begin
          hid_q[1] <= sig_y;
          state_q  <= ST_OUT1;
        end
        ST_OUT1: begin
          acc_q   <= mr;
          state_q <= ST_OUT2;
        end
        ST_OUT2: begin
          sigin_q <= sat32(48'(acc_q) + 48'(mr) - 48'(bias_q[2]));
          state_q <= ST_OSIG;
        end
        ST_OSIG: begin
          o_q     <= sig_y;
          state_q <= ST_OD0;
        end
        ST_OD0: state_q <= ST_OD1;
        ST_OD1: state_q <= ST_OD2;
        ST_OD2: begin
          og_q    <= mr;
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          sq_q    <= mr[16:0];
          h_q     <= 1'b0;
          state_q <= ST_U0;
        end
        ST_U0: state_q <= ST_U1;
        ST_U1: state_q <= ST_U2;
        ST_U2: begin
          who_q[h_q] <= sat32(48'(who_q[h_q]) + 48'(mr));
          state_q    <= ST_U3;
        end
        ST_U3: state_q <= ST_U4;
        ST_U4: state_q <= ST_U5;
        ST_U5: begin
          hg_q    <= mr;
          state_q <= ST_U6;
        end
        ST_U6: begin
          wih_q[{1'b0, h_q}] <= sat32(48'(wih_q[{1'b0, h_q}]) + 48'(mr));
          state_q <= ST_U7;
        end
        ST_U7: begin
          wih_q[{1'b1, h_q}] <= sat32(48'(wih_q[{1'b1, h_q}]) + 48'(mr));
          state_q <= ST_U8;
        end
        ST_U8: begin
          bias_q[{1'b0, h_q}] <= sat32(48'(bias_q[{1'b0, h_q}]) - 48'(mr));
          if (h_q) begin
            state_q <= ST_BO0;
          end else begin
            h_q     <= 1'b1;
            state_q <= ST_U0;
          end
        end
        ST_BO0: state_q <= ST_BO1;
        ST_BO1: begin
          bias_q[2] <= sat32(48'(bias_q[2]) - 48'(mr));
          state_q   <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            mval_q  <= 1'b1;
            mdata_q <= {sq_q, o_q};
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/mbp_checker.sv
module mbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed under stall");

  // One item in work at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready after accept");

  // Sigmoid output stays within one
  a_out_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[16:0] <= 17'd65536)
    else $error("net_output out of range");

  a_sq_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[33:17] <= 17'd65536)
    else $error("squared_error out of range");

endmodule

bind mlp_backprop_train_step_core mbp_checker u_mbp_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o(m_axis_tdata_o)
);
